FILE: rtl/core/lpid_pkg.sv
// ----------------------------------------------------------------------------
// lpid_pkg
// Shared types, constants and fixed-point helpers of the LU inverse block.
// ----------------------------------------------------------------------------
package lpid_pkg;

	localparam int N     = 4;
	localparam int LG    = $clog2(N);
	localparam int CELLS = N * N;
	localparam int CW    = $clog2(CELLS);
	localparam int IXW   = 2;

	localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
	localparam logic signed [31:0] MAXV  = 32'sh7fff_ffff;
	localparam logic signed [31:0] MINV  = 32'sh8000_0000;

	localparam logic [IXW-1:0] CFG_MODE = 2'd0;
	localparam logic [IXW-1:0] CFG_TOL  = 2'd1;

	typedef struct packed {
		logic signed [31:0] element_value;
		logic [3:0]         element_index;
		logic               last_element;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [3:0]         result_index;
		logic               singular;
		logic               overflow;
		logic               last_result;
	} out_item_t;

	typedef struct packed {
		logic        mode;
		logic [30:0] tol;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	typedef struct packed {
		logic signed [31:0] v;
		logic               ovf;
	} sat_t;

	typedef enum logic [4:0] {
		B_IDLE, B_CPR, B_CPW, B_PS, B_PSC, B_SWR, B_SW1, B_SW2, B_PIV, B_DM, B_DR,
		B_NXT, B_ER, B_ED, B_EW, B_MR, B_MM, B_MA, B_BR, B_BX, B_BD, B_BDS, B_BW,
		B_OR, B_OE
	} bst_t;

	typedef enum logic [1:0] {
		CTX_ELIM, CTX_FWD, CTX_BACK
	} ctx_t;

	function automatic logic [CW-1:0] cell_ix(input logic [LG-1:0] r, input logic [LG-1:0] c);
		return CW'(int'(r) * N + int'(c));
	endfunction

	function automatic logic [31:0] magn(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic sat_t qround(input logic signed [63:0] p);
		logic signed [63:0] s;
		logic signed [47:0] r;
		sat_t o;
		s = p + 64'sd32768;
		r = s[63:16];
		if (r[47:31] != {17{r[47]}}) begin
			o.ovf = 1'b1;
			o.v   = r[47] ? MINV : MAXV;
		end else begin
			o.ovf = 1'b0;
			o.v   = r[31:0];
		end
		return o;
	endfunction

	function automatic sat_t qadd(input logic signed [31:0] a, input logic signed [31:0] b,
		input logic sub);
		logic signed [32:0] s;
		sat_t o;
		s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
		if (s[32] != s[31]) begin
			o.ovf = 1'b1;
			o.v   = s[32] ? MINV : MAXV;
		end else begin
			o.ovf = 1'b0;
			o.v   = s[31:0];
		end
		return o;
	endfunction

	function automatic sat_t qneg(input logic signed [31:0] a);
		logic signed [32:0] s;
		sat_t o;
		s = -{a[31], a};
		if (s[32] != s[31]) begin
			o.ovf = 1'b1;
			o.v   = s[32] ? MINV : MAXV;
		end else begin
			o.ovf = 1'b0;
			o.v   = s[31:0];
		end
		return o;
	endfunction

endpackage

FILE: rtl/core/lpid_front.sv
// ----------------------------------------------------------------------------
// lpid_front
// Accepts items into the matrix store, holds configuration, queues jobs.
// ----------------------------------------------------------------------------
module lpid_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  lpid_pkg::in_item_t    item,
	output logic                  busy,
	input  logic                  cfg_valid,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  back_busy,
	input  lpid_pkg::qstat_t      qstat,
	output logic                  push,
	output lpid_pkg::job_t        job,
	input  logic [3:0]            ms_addr,
	output logic [31:0]           ms_rdata
);
	import lpid_pkg::*;

	logic        mode_q;
	logic [30:0] tol_q;
	logic [31:0] ms_mem [CELLS];
	logic        accept;

	assign busy   = !qstat.empty || back_busy;
	assign accept = start && !busy;
	assign push   = accept && item.last_element;
	assign job    = '{mode: mode_q, tol: tol_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			tol_q  <= 31'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[0];
				CFG_TOL:  tol_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (32'(item.element_index) < CELLS))
			ms_mem[item.element_index[CW-1:0]] <= item.element_value;
		ms_rdata <= ms_mem[ms_addr[CW-1:0]];
	end

endmodule

FILE: rtl/core/lpid_queue.sv
// ----------------------------------------------------------------------------
// lpid_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module lpid_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lpid_pkg::job_t   din,
	input  logic             pop,
	output lpid_pkg::job_t   dout,
	output lpid_pkg::qstat_t qstat
);
	import lpid_pkg::*;

	job_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign qstat.empty = (cnt_q == 2'd0);
	assign qstat.full  = (cnt_q == 2'd2);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign dout        = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wp_q <= !wp_q;
			if (do_pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= din;
	end

endmodule

FILE: rtl/core/lpid_div.sv
// ----------------------------------------------------------------------------
// lpid_div
// Q16.16 divider, one quotient bit per cycle, rounded, saturated.
// ----------------------------------------------------------------------------
module lpid_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] q,
	output logic               ovf
);
	import lpid_pkg::*;

	localparam int DW = 50;
	localparam int KW = $clog2(DW + 1);

	logic [DW-1:0] dq_q;
	logic [31:0]   rem_q;
	logic [31:0]   ad_q;
	logic [KW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic          neg_q;
	logic          zero_q;
	logic [32:0]   an;
	logic [31:0]   ad;
	logic [32:0]   trial;
	logic          qbit;

	assign an    = num[32] ? 33'(-num) : 33'(num);
	assign ad    = magn(den);
	assign trial = {rem_q, dq_q[DW-1]};
	assign qbit  = (trial >= {1'b0, ad_q});
	assign done  = done_q;

	always_comb begin
		ovf = 1'b0;
		q   = 32'sd0;
		if (zero_q) begin
			ovf = 1'b1;
		end else if (!neg_q && (dq_q > DW'(MAXV))) begin
			ovf = 1'b1;
			q   = MAXV;
		end else if (neg_q && (dq_q > DW'(33'h0_8000_0000))) begin
			ovf = 1'b1;
			q   = MINV;
		end else begin
			q = neg_q ? -signed'(dq_q[31:0]) : signed'(dq_q[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= (den != 32'sd0);
				done_q <= (den == 32'sd0);
				cnt_q  <= KW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == KW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q   <= DW'({an, 16'd0}) + DW'(ad >> 1);
			rem_q  <= 32'd0;
			ad_q   <= ad;
			neg_q  <= num[32] ^ den[31];
			zero_q <= (den == 32'sd0);
		end else if (run_q) begin
			rem_q <= qbit ? 32'(trial - {1'b0, ad_q}) : trial[31:0];
			dq_q  <= {dq_q[DW-2:0], qbit};
		end
	end

endmodule

FILE: rtl/core/lpid_back.sv
// ----------------------------------------------------------------------------
// lpid_back
// Sequencer: copy, pivoted LU factorization, determinant or substitution, result output.
// ----------------------------------------------------------------------------
module lpid_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpid_pkg::qstat_t      qstat,
	input  lpid_pkg::job_t        job,
	output logic                  pop,
	output logic [3:0]            ms_addr,
	input  logic [31:0]           ms_rdata,
	output logic                  back_busy,
	output logic                  strobe,
	output lpid_pkg::out_item_t   result
);
	import lpid_pkg::*;

	bst_t st_q, st_d;
	ctx_t ctx_q;

	logic signed [31:0] a_mem [CELLS];
	logic signed [31:0] b_mem [CELLS];
	logic signed [31:0] da0_q, da1_q, db0_q, db1_q;
	logic [CW-1:0]      a_ra0, a_ra1, b_ra0, b_ra1, a_wa, b_wa;
	logic signed [31:0] a_wd, b_wd;
	logic               a_we, b_we, rd_en;

	logic [LG-1:0]      j_q, i_q, k_q, best_q;
	logic [CW-1:0]      cnt_q;
	logic [31:0]        bmag_q;
	logic signed [31:0] bval_q, det_q, m_q, x_q;
	logic signed [63:0] prod_q;
	logic               mode_q, sing_q, ovf_q, dovf_q;
	logic [30:0]        tol_q;

	logic signed [31:0] mul_a, mul_b, mac_c;
	logic [31:0]        pmag;
	logic               take;
	logic [LG-1:0]      best_n;
	sat_t               rnd, mac, dneg;

	logic               div_start, div_done, div_ovf;
	logic signed [32:0] div_num;
	logic signed [31:0] div_den, div_q;

	lpid_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.q     (div_q),
		.ovf   (div_ovf)
	);

	assign back_busy = (st_q != B_IDLE);
	assign pmag      = magn(da0_q);
	assign take      = (i_q == j_q) || (pmag > bmag_q);
	assign best_n    = take ? i_q : best_q;
	assign rnd       = qround(prod_q);
	assign mac       = qadd(mac_c, rnd.v, ctx_q == CTX_BACK);
	assign dneg      = qneg(rnd.v);

	always_comb begin
		case (ctx_q)
			CTX_ELIM: begin mul_a = m_q;   mul_b = da1_q; mac_c = da0_q; end
			CTX_FWD:  begin mul_a = da0_q; mul_b = db1_q; mac_c = db0_q; end
			default:  begin mul_a = da0_q; mul_b = db1_q; mac_c = x_q;   end
		endcase
		if (st_q == B_DM) begin
			mul_a = det_q;
			mul_b = bval_q;
		end
	end

	always_comb begin
		st_d      = st_q;
		pop       = 1'b0;
		ms_addr   = 4'(cnt_q);
		a_ra0     = cell_ix(i_q, j_q);
		a_ra1     = cell_ix(j_q, k_q);
		b_ra0     = cell_ix(i_q, k_q);
		b_ra1     = cell_ix(j_q, k_q);
		rd_en     = 1'b0;
		a_we      = 1'b0;
		b_we      = 1'b0;
		a_wa      = cnt_q;
		b_wa      = cnt_q;
		a_wd      = signed'(ms_rdata);
		b_wd      = (cnt_q[CW-1:LG] == cnt_q[LG-1:0]) ? ONE_Q : 32'sd0;
		div_start = 1'b0;
		div_num   = -{da0_q[31], da0_q};
		div_den   = bval_q;
		strobe    = 1'b0;
		result    = '0;
		case (st_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					pop  = 1'b1;
					st_d = B_CPR;
				end
			end
			B_CPR: st_d = B_CPW;
			B_CPW: begin
				a_we = 1'b1;
				b_we = 1'b1;
				st_d = (cnt_q == CW'(CELLS - 1)) ? B_PS : B_CPR;
			end
			B_PS: begin
				rd_en = 1'b1;
				st_d  = B_PSC;
			end
			B_PSC: begin
				if (i_q == LG'(N - 1))
					st_d = (best_n != j_q) ? B_SWR : B_PIV;
				else
					st_d = B_PS;
			end
			B_SWR: begin
				a_ra0 = cell_ix(best_q, k_q);
				b_ra0 = cell_ix(best_q, k_q);
				a_ra1 = cell_ix(j_q, k_q);
				rd_en = 1'b1;
				st_d  = B_SW1;
			end
			B_SW1: begin
				a_we = 1'b1; a_wa = cell_ix(j_q, k_q); a_wd = da0_q;
				b_we = 1'b1; b_wa = cell_ix(j_q, k_q); b_wd = db0_q;
				st_d = B_SW2;
			end
			B_SW2: begin
				a_we = 1'b1; a_wa = cell_ix(best_q, k_q); a_wd = da1_q;
				b_we = 1'b1; b_wa = cell_ix(best_q, k_q); b_wd = db1_q;
				st_d = (k_q == LG'(N - 1)) ? B_PIV : B_SWR;
			end
			B_PIV: begin
				if (bmag_q <= {1'b0, tol_q})
					st_d = B_OR;
				else
					st_d = mode_q ? B_DM : B_NXT;
			end
			B_DM: st_d = B_DR;
			B_DR: st_d = B_NXT;
			B_NXT: begin
				if (j_q == LG'(N - 1))
					st_d = mode_q ? B_OR : B_MR;
				else
					st_d = B_ER;
			end
			B_ER: begin
				rd_en = 1'b1;
				st_d  = B_ED;
			end
			B_ED: begin
				div_start = 1'b1;
				st_d      = B_EW;
			end
			B_EW: begin
				if (div_done) begin
					a_we = 1'b1; a_wa = cell_ix(i_q, j_q); a_wd = div_q;
					st_d = B_MR;
				end
			end
			B_MR: begin
				rd_en = 1'b1;
				if (ctx_q == CTX_ELIM)
					a_ra0 = cell_ix(i_q, k_q);
				st_d = B_MM;
			end
			B_MM: st_d = B_MA;
			B_MA: begin
				case (ctx_q)
					CTX_ELIM: begin
						a_we = 1'b1; a_wa = cell_ix(i_q, k_q); a_wd = mac.v;
						if (k_q == LG'(N - 1))
							st_d = (i_q == LG'(N - 1)) ? B_PS : B_ER;
						else
							st_d = B_MR;
					end
					CTX_FWD: begin
						b_we = 1'b1; b_wa = cell_ix(i_q, k_q); b_wd = mac.v;
						if (k_q == LG'(N - 1) && i_q == LG'(N - 1) && j_q == LG'(N - 2))
							st_d = B_BR;
						else
							st_d = B_MR;
					end
					default: st_d = (j_q == LG'(N - 1)) ? B_BD : B_MR;
				endcase
			end
			B_BR: begin
				rd_en = 1'b1;
				st_d  = B_BX;
			end
			B_BX: st_d = (i_q == LG'(N - 1)) ? B_BD : B_MR;
			B_BD: begin
				a_ra1 = cell_ix(i_q, i_q);
				rd_en = 1'b1;
				st_d  = B_BDS;
			end
			B_BDS: begin
				div_start = 1'b1;
				div_num   = {x_q[31], x_q};
				div_den   = da1_q;
				st_d      = B_BW;
			end
			B_BW: begin
				if (div_done) begin
					b_we = 1'b1; b_wa = cell_ix(i_q, k_q); b_wd = div_q;
					if (i_q == '0)
						st_d = (k_q == LG'(N - 1)) ? B_OR : B_BR;
					else
						st_d = B_BR;
				end
			end
			B_OR: begin
				b_ra0 = cnt_q;
				rd_en = 1'b1;
				st_d  = B_OE;
			end
			B_OE: begin
				strobe              = 1'b1;
				result.result_value = sing_q ? 32'sd0 : (mode_q ? det_q : db0_q);
				result.result_index = mode_q ? 4'd0 : 4'(cnt_q);
				result.singular     = sing_q;
				result.overflow     = ovf_q || (mode_q && !sing_q && dovf_q);
				result.last_result  = mode_q || (cnt_q == CW'(CELLS - 1));
				st_d = result.last_result ? B_IDLE : B_OR;
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= B_IDLE;
		else
			st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		if (a_we)
			a_mem[a_wa] <= a_wd;
		if (b_we)
			b_mem[b_wa] <= b_wd;
		if (rd_en) begin
			da0_q <= a_mem[a_ra0];
			da1_q <= a_mem[a_ra1];
			db0_q <= b_mem[b_ra0];
			db1_q <= b_mem[b_ra1];
		end
		if (st_q == B_DM || st_q == B_MM)
			prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q  <= CTX_ELIM;
			j_q    <= '0;
			i_q    <= '0;
			k_q    <= '0;
			best_q <= '0;
			cnt_q  <= '0;
			bmag_q <= '0;
			bval_q <= '0;
			det_q  <= '0;
			m_q    <= '0;
			x_q    <= '0;
			mode_q <= 1'b0;
			tol_q  <= '0;
			sing_q <= 1'b0;
			ovf_q  <= 1'b0;
			dovf_q <= 1'b0;
		end else begin
			case (st_q)
				B_IDLE: begin
					if (!qstat.empty) begin
						mode_q <= job.mode;
						tol_q  <= job.tol;
						cnt_q  <= '0;
						j_q    <= '0;
						i_q    <= '0;
						ctx_q  <= CTX_ELIM;
						sing_q <= 1'b0;
						ovf_q  <= 1'b0;
						dovf_q <= 1'b0;
						det_q  <= ONE_Q;
					end
				end
				B_CPW: cnt_q <= cnt_q + 1'b1;
				B_PSC: begin
					if (take) begin
						best_q <= i_q;
						bmag_q <= pmag;
						bval_q <= da0_q;
					end
					k_q <= '0;
					if (i_q != LG'(N - 1))
						i_q <= i_q + 1'b1;
				end
				B_SW2: k_q <= k_q + 1'b1;
				B_PIV: begin
					cnt_q <= '0;
					if (bmag_q <= {1'b0, tol_q})
						sing_q <= 1'b1;
				end
				B_DR: begin
					if (best_q != j_q) begin
						det_q  <= dneg.v;
						dovf_q <= dovf_q | rnd.ovf | dneg.ovf;
					end else begin
						det_q  <= rnd.v;
						dovf_q <= dovf_q | rnd.ovf;
					end
				end
				B_NXT: begin
					cnt_q <= '0;
					if (j_q == LG'(N - 1)) begin
						ctx_q <= CTX_FWD;
						j_q   <= '0;
						i_q   <= LG'(1);
						k_q   <= '0;
					end else begin
						i_q <= j_q + 1'b1;
					end
				end
				B_EW: begin
					if (div_done) begin
						m_q   <= div_q;
						ovf_q <= ovf_q | div_ovf;
						k_q   <= j_q + 1'b1;
						ctx_q <= CTX_ELIM;
					end
				end
				B_MA: begin
					ovf_q <= ovf_q | rnd.ovf | mac.ovf;
					case (ctx_q)
						CTX_ELIM: begin
							if (k_q == LG'(N - 1)) begin
								if (i_q == LG'(N - 1)) begin
									j_q <= j_q + 1'b1;
									i_q <= j_q + 1'b1;
								end else begin
									i_q <= i_q + 1'b1;
								end
							end else begin
								k_q <= k_q + 1'b1;
							end
						end
						CTX_FWD: begin
							if (k_q == LG'(N - 1)) begin
								k_q <= '0;
								if (i_q == LG'(N - 1)) begin
									if (j_q == LG'(N - 2)) begin
										i_q <= LG'(N - 1);
									end else begin
										j_q <= j_q + 1'b1;
										i_q <= j_q + LG'(2);
									end
								end else begin
									i_q <= i_q + 1'b1;
								end
							end else begin
								k_q <= k_q + 1'b1;
							end
						end
						default: begin
							x_q <= mac.v;
							if (j_q != LG'(N - 1))
								j_q <= j_q + 1'b1;
						end
					endcase
				end
				B_BX: begin
					x_q   <= db0_q;
					j_q   <= i_q + 1'b1;
					ctx_q <= CTX_BACK;
				end
				B_BW: begin
					if (div_done) begin
						ovf_q <= ovf_q | div_ovf;
						cnt_q <= '0;
						if (i_q == '0) begin
							k_q <= k_q + 1'b1;
							i_q <= LG'(N - 1);
						end else begin
							i_q <= i_q - 1'b1;
						end
					end
				end
				B_OE: cnt_q <= cnt_q + 1'b1;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/lu_pivot_inverse_determinant_4x4_top.sv
// ----------------------------------------------------------------------------
// lu_pivot_inverse_determinant_4x4_top
// 4x4 Q16.16 LU factorization with partial pivoting: inverse or determinant.
// ----------------------------------------------------------------------------
// Items: one matrix element per item, taken when start is high and busy low.
// The item with last_element set queues a job; busy stays high until all of
// its results have left. Results appear for one cycle each with strobe high:
// 16 elements in row-major order in inverse mode, one in determinant mode.
// The receiver cannot stall; results are never held.
// Configuration: cfg_valid/cfg_ready write channel, always ready; index 0 is
// operation_mode, index 1 zero_tolerance; write only while busy is low.
// The time from the last item to the results is set by the bit-serial
// divider (6 quotients in factorization, 16 in back substitution) and
// the multiply-accumulate step of the sequencer (states MR, MM, MA);
// a copy of the matrix store opens each job. Singular matrices finish early.
// Reset clears control state and loads operation_mode 0, zero_tolerance 1.
// ----------------------------------------------------------------------------
module lu_pivot_inverse_determinant_4x4_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  lpid_pkg::in_item_t   item,
	output logic                 busy,
	output logic                 strobe,
	output lpid_pkg::out_item_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import lpid_pkg::*;

	logic        back_busy;
	logic        push;
	logic        pop;
	job_t        job_in;
	job_t        job_out;
	qstat_t      qstat;
	logic [3:0]  ms_addr;
	logic [31:0] ms_rdata;

	assign cfg_ready = 1'b1;

	lpid_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.busy     (busy),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.back_busy(back_busy),
		.qstat    (qstat),
		.push     (push),
		.job      (job_in),
		.ms_addr  (ms_addr),
		.ms_rdata (ms_rdata)
	);

	lpid_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (job_in),
		.pop   (pop),
		.dout  (job_out),
		.qstat (qstat)
	);

	lpid_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.job      (job_out),
		.pop      (pop),
		.ms_addr  (ms_addr),
		.ms_rdata (ms_rdata),
		.back_busy(back_busy),
		.strobe   (strobe),
		.result   (result)
	);

endmodule

FILE: tb/tb_lu_pivot_inverse_determinant_4x4_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lu_pivot_inverse_determinant_4x4_top
// Loads 4x4 Q16.16 matrices element by element and checks every inverse
// element or determinant against a fixed-point LU model kept in this bench.
// ----------------------------------------------------------------------------
module tb_lu_pivot_inverse_determinant_4x4_top;
	import lpid_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	in_item_t    item = '0;
	logic        busy;
	logic        strobe;
	out_item_t   result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	lu_pivot_inverse_determinant_4x4_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.strobe(strobe), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	in_item_t  elem_q[$];
	out_item_t expected_q[$];
	int        n_err, n_items, n_jobs, n_results, n_queued, gap_cnt;
	bit        no_gaps;

	// bench copy of block state
	logic        pm_mode = 1'b0;
	logic [30:0] pm_tol = 31'd1;
	int          mat[CELLS];
	int          lu[CELLS];
	int          sol[CELLS];
	int          piv[N-1];
	bit          sat_seen;

	function automatic int q_sat(input longint v);
		if (v > longint'(MAXV)) begin
			sat_seen = 1'b1;
			return MAXV;
		end
		if (v < longint'(MINV)) begin
			sat_seen = 1'b1;
			return MINV;
		end
		return int'(v);
	endfunction

	function automatic int q_mul(input int a, input int b);
		longint p;
		p = longint'(a) * longint'(b) + 64'sd32768;
		return q_sat(p >>> 16);
	endfunction

	function automatic int q_div(input longint n, input int d);
		longint num, an, ad, q;
		if (d == 0) begin
			sat_seen = 1'b1;
			return 0;
		end
		num = n * 65536;
		an = num < 0 ? -num : num;
		ad = d < 0 ? -longint'(d) : longint'(d);
		q = (an + ad / 2) / ad;
		if ((num < 0) != (d < 0))
			q = -q;
		return q_sat(q);
	endfunction

	function automatic longint q_mag(input int a);
		return a < 0 ? -longint'(a) : longint'(a);
	endfunction

	function automatic bit lu_factor();
		int best, t, m;
		for (int j = 0; j < N; j++) begin
			best = j;
			for (int i = j + 1; i < N; i++)
				if (q_mag(lu[i*N+j]) > q_mag(lu[best*N+j]))
					best = i;
			if (j < N - 1)
				piv[j] = best;
			if (best != j) begin
				for (int k = 0; k < N; k++) begin
					t = lu[best*N+k];
					lu[best*N+k] = lu[j*N+k];
					lu[j*N+k] = t;
				end
			end
			if (q_mag(lu[j*N+j]) <= longint'(pm_tol))
				return 1'b0;
			for (int i = j + 1; i < N; i++) begin
				m = q_div(-longint'(lu[i*N+j]), lu[j*N+j]);
				lu[i*N+j] = m;
				for (int k = j + 1; k < N; k++)
					lu[i*N+k] = q_sat(longint'(lu[i*N+k]) + longint'(q_mul(m, lu[j*N+k])));
			end
		end
		return 1'b1;
	endfunction

	function automatic void lu_solve();
		int b[CELLS];
		int t, x, r;
		for (int i = 0; i < CELLS; i++)
			b[i] = (i / N == i % N) ? ONE_Q : 0;
		for (int i = 0; i < N - 1; i++) begin
			r = piv[i];
			if (r != i) begin
				for (int j = 0; j < N; j++) begin
					t = b[i*N+j];
					b[i*N+j] = b[r*N+j];
					b[r*N+j] = t;
				end
			end
		end
		for (int j = 0; j < N - 1; j++)
			for (int i = j + 1; i < N; i++)
				for (int k = 0; k < N; k++)
					b[i*N+k] = q_sat(longint'(b[i*N+k]) + longint'(q_mul(lu[i*N+j], b[j*N+k])));
		for (int k = 0; k < N; k++)
			for (int i = N - 1; i >= 0; i--) begin
				x = b[i*N+k];
				for (int j = i + 1; j < N; j++)
					x = q_sat(longint'(x) - longint'(q_mul(lu[i*N+j], sol[j*N+k])));
				sol[i*N+k] = q_div(longint'(x), lu[i*N+i]);
			end
	endfunction

	function automatic void predict_results(input in_item_t it);
		bit ok;
		int d;
		out_item_t o;
		mat[it.element_index] = it.element_value;
		if (!it.last_element)
			return;
		n_jobs++;
		sat_seen = 1'b0;
		lu = mat;
		ok = lu_factor();
		if (pm_mode) begin
			d = 0;
			if (ok) begin
				d = ONE_Q;
				for (int i = 0; i < N - 1; i++) begin
					d = q_mul(d, lu[i*N+i]);
					if (piv[i] != i)
						d = q_sat(-longint'(d));
				end
				d = q_mul(d, lu[CELLS-1]);
			end
			o.result_value = d;
			o.result_index = '0;
			o.singular     = !ok;
			o.overflow     = sat_seen;
			o.last_result  = 1'b1;
			expected_q.push_back(o);
			return;
		end
		if (ok)
			lu_solve();
		for (int i = 0; i < CELLS; i++) begin
			o.result_value = ok ? sol[i] : 0;
			o.result_index = i[3:0];
			o.singular     = !ok;
			o.overflow     = sat_seen;
			o.last_result  = (i == CELLS - 1);
			expected_q.push_back(o);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 11)
			return 0;
		if (r < 18)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_results(item);
				n_items++;
			end
			if (!(start && busy)) begin
				if (gap_cnt > 0) begin
					gap_cnt--;
					start <= 1'b0;
				end else if (elem_q.size() > 0) begin
					item <= elem_q.pop_front();
					start <= 1'b1;
					gap_cnt = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && strobe) begin
			n_results++;
			if (expected_q.size() == 0) begin
				$error("unexpected result index %0d value %h", result.result_index,
					result.result_value);
				n_err++;
			end else begin
				e = expected_q.pop_front();
				if (result.result_value !== e.result_value) begin
					$error("result_value exp %h got %h", e.result_value, result.result_value);
					n_err++;
				end
				if (result.result_index !== e.result_index) begin
					$error("result_index exp %0d got %0d", e.result_index, result.result_index);
					n_err++;
				end
				if (result.singular !== e.singular) begin
					$error("singular exp %0d got %0d", e.singular, result.singular);
					n_err++;
				end
				if (result.overflow !== e.overflow) begin
					$error("overflow exp %0d got %0d", e.overflow, result.overflow);
					n_err++;
				end
				if (result.last_result !== e.last_result) begin
					$error("last_result exp %0d got %0d", e.last_result, result.last_result);
					n_err++;
				end
			end
		end
	end

	task automatic add_elem(input int v, input int ix, input bit last);
		in_item_t it;
		it.element_value = v;
		it.element_index = ix[3:0];
		it.last_element  = last;
		elem_q.push_back(it);
		n_queued++;
	endtask

	function automatic int rand_elem(input int kind, input int ix);
		int v;
		case (kind)
			0: begin
				v = $urandom_range(0, 8 * 65536) - 4 * 65536;
				if (ix / N == ix % N)
					v = v + ($urandom_range(0, 1) ? 9 : -9) * 65536;
			end
			1: v = $urandom;
			2: v = $urandom_range(0, 512) - 256;
			default: v = $urandom_range(0, 2 * 65536) - 65536;
		endcase
		return v;
	endfunction

	task automatic add_matrix(input int kind);
		int zr, v;
		zr = $urandom_range(0, N - 1);
		for (int ix = 0; ix < CELLS; ix++) begin
			v = rand_elem(kind, ix);
			if (kind == 3 && ix / N == zr)
				v = 0;
			add_elem(v, ix, ix == CELLS - 1);
		end
	endtask

	task automatic wait_idle();
		wait (elem_q.size() == 0 && gap_cnt == 0);
		@(posedge clk);
		while (start || expected_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] ix, input logic [31:0] d);
		cfg_index <= ix;
		cfg_data  <= d;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (ix == CFG_MODE)
			pm_mode = d[0];
		else
			pm_tol = d[30:0];
	endtask

	task automatic random_phase(input int count);
		int r, nu, lim;
		lim = n_queued + count;
		while (n_queued < lim) begin
			r = $urandom_range(0, 19);
			if (r < 12) begin
				add_matrix($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
			end else if (r < 17) begin
				nu = $urandom_range(0, 2);
				for (int i = 0; i < nu; i++)
					add_elem(rand_elem($urandom_range(0, 2), 0), $urandom_range(0, 15), 1'b0);
				add_elem(rand_elem($urandom_range(0, 3), 0), $urandom_range(0, 15), 1'b1);
			end else begin
				nu = $urandom_range(2, 6);
				for (int i = 0; i < nu; i++)
					add_elem($urandom, $urandom_range(0, 15), 1'b0);
				add_elem($urandom, $urandom_range(0, 15), 1'b1);
			end
		end
	endtask

	logic [31:0] mode_set[6] = '{0, 1, 0, 1, 0, 1};
	logic [31:0] tol_set[6];

	initial begin
		tol_set = '{1, 1, 0, 32'h7fff_ffff, 0, 0};
		tol_set[4] = $urandom_range(0, 70000);
		tol_set[5] = $urandom_range(0, 70000);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 6; p++) begin
			cfg_write(CFG_MODE, mode_set[p]);
			cfg_write(CFG_TOL, tol_set[p]);
			no_gaps = (p == 2);
			if (p == 0) begin
				for (int ix = 0; ix < CELLS; ix++)
					add_elem((ix / N == ix % N) ? ONE_Q : 0, ix, ix == CELLS - 1);
				add_elem(MINV, 15, 1'b1);
				add_elem(MAXV, 5, 1'b1);
				add_elem(0, 0, 1'b1);
				add_elem(MAXV, 0, 1'b1);
				add_elem(-ONE_Q, 10, 1'b1);
				wait_idle();
			end
			random_phase(p < 4 ? 55 : 65);
			wait_idle();
		end
		repeat (200) @(posedge clk);
		$display("covered %0d items, %0d matrix jobs, %0d results over 6 mode/tolerance settings",
			n_items, n_jobs, n_results);
		if (n_err == 0 && expected_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
